// ===== rtl/spcm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and functions for the sensor packet encoder.
// No dependencies; every other file of the block refers to it, but for spcm_in_if, spcm_out_if and spcm_checker.
package spcm_pkg;

  localparam int unsigned SerialWidth = 20;
  localparam int unsigned IndexWidth  = 2;
  localparam int unsigned CrcWidth    = 12;

  localparam logic [CrcWidth-1:0]    CrcPoly    = 12'h805;
  localparam logic [7:0]             PreambleHi = 8'hFF;
  localparam logic [7:0]             PreambleLo = 8'hFE;
  localparam logic [3:0]             SerialTag  = 4'hA;
  localparam logic [SerialWidth-1:0] SerialRst  = 20'hF6732;

  localparam logic [IndexWidth-1:0] RegSerial       = 2'd0;
  localparam logic [IndexWidth-1:0] RegInvertDoor   = 2'd1;
  localparam logic [IndexWidth-1:0] RegInvertTamper = 2'd2;

  typedef struct packed {
    logic door_flag;
    logic tamper_flag;
  } flags_t;

  typedef struct packed {
    logic   valid;
    flags_t flags;
  } q_slot_t;

  function automatic logic [CrcWidth-1:0] crc12_nibble(input logic [CrcWidth-1:0] crc,
                                                       input logic [3:0] nib);
    logic [CrcWidth-1:0] c;
    c = crc ^ {nib, 8'h00};
    for (int i = 0; i < 4; i++) begin
      if (c[CrcWidth-1]) begin
        c = {c[CrcWidth-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[CrcWidth-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] manchester(input logic [3:0] nib);
    logic [7:0] r;
    for (int i = 0; i < 4; i++) begin
      r[2*i +: 2] = {~nib[i], nib[i]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/spcm_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: one sample of the door and tamper pin levels per transaction.
// No dependencies.
interface spcm_in_if;
  logic valid;
  logic ready;
  logic door_level;
  logic tamper_level;
  modport source (output valid, output door_level, output tamper_level, input ready);
  modport sink (input valid, input door_level, input tamper_level, output ready);
endinterface

// ===== rtl/spcm_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel: register index and write data per transaction.
// Depends on spcm_pkg for the field widths.
interface spcm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [spcm_pkg::IndexWidth-1:0]     index;
  logic [spcm_pkg::SerialWidth-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/spcm_out_if.sv =====
`timescale 1ns / 1ps
// Output channel: one Manchester coded byte with its frame position per transaction.
// No dependencies.
interface spcm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] coded_byte;
  logic [3:0] byte_position;
  logic       last_byte;
  modport source (output valid, output coded_byte, output byte_position,
                  output last_byte, input ready);
  modport sink (input valid, input coded_byte, input byte_position,
                input last_byte, output ready);
endinterface

// ===== rtl/spcm_front.sv =====
`timescale 1ns / 1ps
// Front end: configuration registers and intake of samples, which are turned
// into status flags and pushed into the queue. Depends on spcm_pkg and the interfaces.
module spcm_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  spcm_in_if.sink                          in_if,
  spcm_cfg_if.sink                         cfg_if,
  input  logic                             q_full_i,
  output spcm_pkg::q_slot_t                push_o,
  output logic [spcm_pkg::SerialWidth-1:0] serial_o
);

  logic [spcm_pkg::SerialWidth-1:0] serial_q, serial_d;
  logic                             inv_door_q, inv_door_d;
  logic                             inv_tamper_q, inv_tamper_d;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = ~q_full_i;

  always_comb begin
    serial_d     = serial_q;
    inv_door_d   = inv_door_q;
    inv_tamper_d = inv_tamper_q;
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        spcm_pkg::RegSerial:       serial_d     = cfg_if.data;
        spcm_pkg::RegInvertDoor:   inv_door_d   = cfg_if.data[0];
        spcm_pkg::RegInvertTamper: inv_tamper_d = cfg_if.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      serial_q     <= spcm_pkg::SerialRst;
      inv_door_q   <= 1'b1;
      inv_tamper_q <= 1'b1;
    end else begin
      serial_q     <= serial_d;
      inv_door_q   <= inv_door_d;
      inv_tamper_q <= inv_tamper_d;
    end
  end

  always_comb begin
    push_o.valid             = in_if.valid & ~q_full_i;
    push_o.flags.door_flag   = in_if.door_level ^ inv_door_q;
    push_o.flags.tamper_flag = in_if.tamper_level ^ inv_tamper_q;
  end

  assign serial_o = serial_q;

endmodule

// ===== rtl/spcm_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue of status flags between the front end and the frame builder.
// Depends on spcm_pkg.
module spcm_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spcm_pkg::q_slot_t push_i,
  output logic              full_o,
  input  logic              pop_i,
  output spcm_pkg::q_slot_t head_o
);

  spcm_pkg::flags_t mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i.valid;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i.valid} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.flags;
    end
  end

  assign full_o       = cnt_q[1];
  assign head_o.valid = cnt_q != 2'd0;
  assign head_o.flags = mem_q[rd_ptr_q];

endmodule

// ===== rtl/spcm_back.sv =====
`timescale 1ns / 1ps
// Frame builder: computes the CRC a nibble per cycle and emits sixteen
// Manchester coded bytes per queued sample. Depends on spcm_pkg and spcm_out_if.
module spcm_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  spcm_pkg::q_slot_t                head_i,
  output logic                             pop_o,
  input  logic [spcm_pkg::SerialWidth-1:0] serial_i,
  spcm_out_if.source                       out_if
);

  logic                          busy_q, busy_d;
  logic [3:0]                    pos_q, pos_d;
  spcm_pkg::flags_t              flags_q, flags_d;
  logic [spcm_pkg::CrcWidth-1:0] crc_q, crc_d;
  logic [3:0]                    crc_cnt_q, crc_cnt_d;

  logic                          out_valid_q, out_valid_d;
  logic [7:0]                    coded_q, coded_d;
  logic [3:0]                    opos_q, opos_d;
  logic                          last_q, last_d;

  logic        crc_done, out_free, produce, last_now;
  logic [31:0] crc_word;
  logic [3:0]  crc_nib;
  logic [7:0]  pkt_byte;
  logic [3:0]  nib;

  assign crc_done = crc_cnt_q[3];
  assign crc_word = {spcm_pkg::SerialTag, serial_i, flags_q.door_flag,
                     flags_q.tamper_flag, 6'b0};
  assign crc_nib  = crc_word[{~crc_cnt_q[2:0], 2'b00} +: 4];

  assign out_free = ~out_valid_q | out_if.ready;
  assign produce  = busy_q & out_free & (~(pos_q[3] & pos_q[2]) | crc_done);
  assign last_now = produce & (pos_q == 4'd15);
  assign pop_o    = head_i.valid & (~busy_q | last_now);

  always_comb begin
    unique case (pos_q[3:1])
      3'd0: pkt_byte = spcm_pkg::PreambleHi;
      3'd1: pkt_byte = spcm_pkg::PreambleLo;
      3'd2: pkt_byte = {spcm_pkg::SerialTag, serial_i[19:16]};
      3'd3: pkt_byte = serial_i[15:8];
      3'd4: pkt_byte = serial_i[7:0];
      3'd5: pkt_byte = {flags_q.door_flag, flags_q.tamper_flag, 6'b0};
      3'd6: pkt_byte = crc_q[11:4];
      3'd7: pkt_byte = {crc_q[3:0], 4'h0};
    endcase
    nib = pos_q[0] ? pkt_byte[3:0] : pkt_byte[7:4];
  end

  always_comb begin
    busy_d    = busy_q;
    pos_d     = pos_q;
    flags_d   = flags_q;
    crc_d     = crc_q;
    crc_cnt_d = crc_cnt_q;
    if (produce) begin
      pos_d = pos_q + 4'd1;
    end
    if (last_now) begin
      busy_d = 1'b0;
    end
    if (pop_o) begin
      busy_d    = 1'b1;
      pos_d     = 4'd0;
      flags_d   = head_i.flags;
      crc_d     = '0;
      crc_cnt_d = 4'd0;
    end else if (!crc_done) begin
      crc_d     = spcm_pkg::crc12_nibble(crc_q, crc_nib);
      crc_cnt_d = crc_cnt_q + 4'd1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q & ~out_if.ready;
    coded_d     = coded_q;
    opos_d      = opos_q;
    last_d      = last_q;
    if (produce) begin
      out_valid_d = 1'b1;
      coded_d     = spcm_pkg::manchester(nib);
      opos_d      = pos_q;
      last_d      = pos_q == 4'd15;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= 4'd0;
      crc_cnt_q   <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pos_q       <= pos_d;
      crc_cnt_q   <= crc_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flags_q <= flags_d;
    crc_q   <= crc_d;
    coded_q <= coded_d;
    opos_q  <= opos_d;
    last_q  <= last_d;
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.coded_byte    = coded_q;
  assign out_if.byte_position = opos_q;
  assign out_if.last_byte     = last_q;

endmodule

// ===== rtl/sensor_packet_crc12_manchester.sv =====
`timescale 1ns / 1ps
// Top level of the sensor packet encoder with CRC-12 and Manchester coding.
// Depends on spcm_pkg, the channel interfaces, spcm_front, spcm_queue and spcm_back.
//
// Usage:
//   in_if carries one sample of the door and tamper pin levels per transaction.
//   out_if returns sixteen transactions per sample: the Manchester coded bytes
//   of the packet, high nibble first, with their position and a last-byte mark.
//   cfg_if writes the serial number (index 0) and the door and tamper inversions
//   (indices 1 and 2); other indices are ignored. Writes are always accepted.
// Timing:
//   A sample is registered in the queue, then in the frame builder; its coded bytes
//   go out through the output register, one per cycle while the receiver is ready.
//   The next sample is taken from the queue as the last byte is produced. The CRC is
//   worked out four bits per cycle, overlapped with the first twelve coded bytes.
// Reset and stalls:
//   Reset empties the queue and output register and restores the register reset
//   values. When the receiver holds ready low the output byte stays put; the
//   two-entry queue keeps taking samples until it is full.
module sensor_packet_crc12_manchester (
  input  logic       clk_i,
  input  logic       rst_ni,
  spcm_in_if.sink    in_if,
  spcm_cfg_if.sink   cfg_if,
  spcm_out_if.source out_if
);

  spcm_pkg::q_slot_t                push;
  spcm_pkg::q_slot_t                head;
  logic                             q_full;
  logic                             pop;
  logic [spcm_pkg::SerialWidth-1:0] serial;

  spcm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_if    (in_if),
    .cfg_if   (cfg_if),
    .q_full_i (q_full),
    .push_o   (push),
    .serial_o (serial)
  );

  spcm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  spcm_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .pop_o    (pop),
    .serial_i (serial),
    .out_if   (out_if)
  );

endmodule

// ===== rtl/spcm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the encoder output, attached to the top level by bind.
// Depends on sensor_packet_crc12_manchester.
module spcm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] coded_byte_i,
  input logic [3:0] byte_position_i,
  input logic       last_byte_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(coded_byte_i)
      && $stable(byte_position_i) && $stable(last_byte_i))
    else $error("Stalled output transaction changed.");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> last_byte_i == (byte_position_i == 4'd15))
    else $error("Last-byte mark disagrees with the position.");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (coded_byte_i[7] != coded_byte_i[6]) && (coded_byte_i[5] != coded_byte_i[4])
      && (coded_byte_i[3] != coded_byte_i[2]) && (coded_byte_i[1] != coded_byte_i[0]))
    else $error("Coded byte is not a valid Manchester pattern.");

  a_preamble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (byte_position_i == 4'd0 || byte_position_i == 4'd1
      || byte_position_i == 4'd2) |-> coded_byte_i == 8'h55)
    else $error("Preamble byte is wrong.");

  a_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("Output valid during reset.");

endmodule

bind sensor_packet_crc12_manchester spcm_checker u_spcm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_if.valid),
  .out_ready_i     (out_if.ready),
  .coded_byte_i    (out_if.coded_byte),
  .byte_position_i (out_if.byte_position),
  .last_byte_i     (out_if.last_byte)
);
